>>> rtl/bbvp_pkg.sv
// shared types and constants of the buck-boost voltage loop
// no dependencies; imported by the controller, datapath and top level
package bbvp_pkg;

    // converter modes
    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_BUCK  = 2'd1;
    localparam logic [1:0] MODE_BOOST = 2'd2;
    localparam logic [1:0] MODE_MIX   = 2'd3;

    // configuration register indexes
    localparam logic [2:0] REG_CAL_GAIN       = 3'd0;
    localparam logic [2:0] REG_CAL_OFFSET     = 3'd1;
    localparam logic [2:0] REG_BUCK_MAX_DUTY  = 3'd2;
    localparam logic [2:0] REG_BOOST_MAX_DUTY = 3'd3;
    localparam logic [2:0] REG_BUCK_MIN_DUTY  = 3'd4;
    localparam logic [2:0] REG_BOOST_MIN_DUTY = 3'd5;
    localparam logic [2:0] REG_PWM_PERIOD     = 3'd6;

    // configuration reset values
    localparam logic [15:0] RST_CAL_GAIN       = 16'd4096;
    localparam logic [15:0] RST_CAL_OFFSET     = 16'd0;
    localparam logic [11:0] RST_BUCK_MAX_DUTY  = 12'd3809;
    localparam logic [11:0] RST_BOOST_MAX_DUTY = 12'd2867;
    localparam logic [11:0] RST_BUCK_MIN_DUTY  = 12'd205;
    localparam logic [11:0] RST_BOOST_MIN_DUTY = 12'd205;
    localparam logic [15:0] RST_PWM_PERIOD     = 16'd32000;

    // fixed duties of the inactive stage
    localparam logic [11:0] BUCK_DUTY_IN_BOOST = 12'd3809;
    localparam logic [11:0] BUCK_DUTY_IN_MIX   = 12'd3277;
    localparam logic [11:0] BOOST_DUTY_IN_BUCK = 12'd287;

    // incremental pid coefficients, q8
    localparam logic signed [16:0] BK0 = 17'sd5203;
    localparam logic signed [16:0] BK1 = -17'sd10246;
    localparam logic signed [16:0] BK2 = 17'sd5044;
    localparam logic signed [16:0] BS0 = 17'sd8860;
    localparam logic signed [16:0] BS1 = -17'sd17445;
    localparam logic signed [16:0] BS2 = 17'sd8588;

    localparam logic signed [17:0] ERR_CAP = 18'sd30;

    // operand selection of the shared multiplier
    typedef enum logic [2:0] {
        MUL_CAL   = 3'd0,
        MUL_E0    = 3'd1,
        MUL_E1    = 3'd2,
        MUL_E2    = 3'd3,
        MUL_BUCK  = 3'd4,
        MUL_BOOST = 3'd5
    } t_mul_src;

    // controller to datapath commands
    typedef struct packed {
        logic     load;
        logic     mul_en;
        t_mul_src mul_src;
        logic     err_calc;
        logic     acc_init;
        logic     acc_add;
        logic     duty_upd;
        logic     bc_cap;
        logic     out_load;
    } t_dp_cmd;

endpackage

>>> rtl/bbvp_ctrl.sv
// sequencer of the voltage loop: steps one beat through the shared datapath
// depends on bbvp_pkg
module bbvp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output bbvp_pkg::t_dp_cmd o_cmd
);
    import bbvp_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_CAL  = 11'b000_0000_0010,
        S_ERR  = 11'b000_0000_0100,
        S_E0   = 11'b000_0000_1000,
        S_E1   = 11'b000_0001_0000,
        S_E2   = 11'b000_0010_0000,
        S_SUM  = 11'b000_0100_0000,
        S_DUTY = 11'b000_1000_0000,
        S_SBK  = 11'b001_0000_0000,
        S_SBS  = 11'b010_0000_0000,
        S_FIN  = 11'b100_0000_0000
    } t_state;

    t_state  r_state, n_state;
    logic    r_out_valid, n_out_valid;
    logic    w_in_accept;
    logic    w_out_free;
    t_dp_cmd w_cmd;

    assign w_in_accept = i_in_valid && (r_state == S_IDLE);
    assign w_out_free  = !(r_out_valid && i_out_stall);

    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        w_cmd.mul_src = MUL_CAL;
        unique case (r_state)
            S_IDLE: begin
                w_cmd.load = w_in_accept;
                if (w_in_accept) n_state = S_CAL;
            end
            S_CAL: begin
                w_cmd.mul_en  = 1'b1;
                w_cmd.mul_src = MUL_CAL;
                n_state = S_ERR;
            end
            S_ERR: begin
                w_cmd.err_calc = 1'b1;
                n_state = S_E0;
            end
            S_E0: begin
                w_cmd.mul_en   = 1'b1;
                w_cmd.mul_src  = MUL_E0;
                w_cmd.acc_init = 1'b1;
                n_state = S_E1;
            end
            S_E1: begin
                w_cmd.mul_en  = 1'b1;
                w_cmd.mul_src = MUL_E1;
                w_cmd.acc_add = 1'b1;
                n_state = S_E2;
            end
            S_E2: begin
                w_cmd.mul_en  = 1'b1;
                w_cmd.mul_src = MUL_E2;
                w_cmd.acc_add = 1'b1;
                n_state = S_SUM;
            end
            S_SUM: begin
                w_cmd.acc_add = 1'b1;
                n_state = S_DUTY;
            end
            S_DUTY: begin
                w_cmd.duty_upd = 1'b1;
                n_state = S_SBK;
            end
            S_SBK: begin
                w_cmd.mul_en  = 1'b1;
                w_cmd.mul_src = MUL_BUCK;
                n_state = S_SBS;
            end
            S_SBS: begin
                w_cmd.mul_en  = 1'b1;
                w_cmd.mul_src = MUL_BOOST;
                w_cmd.bc_cap  = 1'b1;
                n_state = S_FIN;
            end
            S_FIN: begin
                // hold here while the previous result is still stalled
                w_cmd.out_load = w_out_free;
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) n_out_valid = 1'b0;
        if (w_cmd.out_load) n_out_valid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = w_cmd;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_CAL))
        else $error("accepted beat did not start the sequence");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> !(r_out_valid && i_out_stall))
        else $error("result register overwritten while stalled");

    a_valid_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_FIN))
        else $error("result valid raised outside the final step");

    a_fin_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && w_out_free) |=> (r_state == S_IDLE))
        else $error("sequence did not return to idle");

endmodule

>>> rtl/bbvp_datapath.sv
// datapath of the voltage loop: config registers, shared multiplier,
// pid accumulator, clamps and result registers; depends on bbvp_pkg
module bbvp_datapath #(
    parameter logic [11:0] P_BUCK_DUTY_IN_BOOST = bbvp_pkg::BUCK_DUTY_IN_BOOST,
    parameter logic [11:0] P_BUCK_DUTY_IN_MIX   = bbvp_pkg::BUCK_DUTY_IN_MIX,
    parameter logic [11:0] P_BOOST_DUTY_IN_BUCK = bbvp_pkg::BOOST_DUTY_IN_BUCK
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bbvp_pkg::t_dp_cmd i_cmd,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data,
    input  logic [11:0]       i_adc_sample,
    input  logic [15:0]       i_target_voltage,
    input  logic [1:0]        i_converter_mode,
    input  logic              i_mode_changed,
    input  logic              i_pwm_enable,
    output logic [11:0]       o_buck_duty,
    output logic [11:0]       o_boost_duty,
    output logic [15:0]       o_buck_compare,
    output logic [14:0]       o_adc_trigger_compare,
    output logic [15:0]       o_boost_compare
);
    import bbvp_pkg::*;

    localparam logic signed [36:0] ACC_MAX = 37'sd2147483647;
    localparam logic signed [36:0] ACC_MIN = -37'sd2147483648;

    // configuration
    logic        [15:0] r_cal_gain;
    logic signed [15:0] r_cal_offset;
    logic        [11:0] r_buck_max, r_boost_max, r_buck_min, r_boost_min;
    logic        [15:0] r_pwm_period;

    // captured beat
    logic [11:0] r_adc;
    logic [15:0] r_tgt;
    logic [1:0]  r_mode;
    logic        r_chg, r_en;

    // loop state
    logic signed [17:0] r_err, r_err_p1, r_err_p2;
    logic signed [31:0] r_integ;
    logic        [11:0] r_held_buck, r_held_boost;

    // working registers
    logic signed [34:0] r_prod;
    logic signed [36:0] r_acc;
    logic        [15:0] r_bc;

    // results
    logic [11:0] r_out_buck, r_out_boost;
    logic [15:0] r_out_bc, r_out_boc;
    logic [14:0] r_out_abc;

    logic signed [17:0] w_mul_a;
    logic signed [16:0] w_mul_b;
    logic               w_is_buck;
    logic signed [17:0] w_vout, w_err;
    logic signed [31:0] w_u;
    logic signed [23:0] w_d;

    function automatic logic [11:0] clamp_duty(logic signed [23:0] d,
                                               logic [11:0] lo, logic [11:0] hi);
        logic signed [23:0] t;
        t = d;
        if (t > $signed({12'b0, hi})) t = $signed({12'b0, hi});
        if (t < $signed({12'b0, lo})) t = $signed({12'b0, lo});
        return t[11:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_gain   <= RST_CAL_GAIN;
            r_cal_offset <= $signed(RST_CAL_OFFSET);
            r_buck_max   <= RST_BUCK_MAX_DUTY;
            r_boost_max  <= RST_BOOST_MAX_DUTY;
            r_buck_min   <= RST_BUCK_MIN_DUTY;
            r_boost_min  <= RST_BOOST_MIN_DUTY;
            r_pwm_period <= RST_PWM_PERIOD;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_CAL_GAIN:       r_cal_gain   <= i_cfg_data;
                REG_CAL_OFFSET:     r_cal_offset <= $signed(i_cfg_data);
                REG_BUCK_MAX_DUTY:  r_buck_max   <= i_cfg_data[11:0];
                REG_BOOST_MAX_DUTY: r_boost_max  <= i_cfg_data[11:0];
                REG_BUCK_MIN_DUTY:  r_buck_min   <= i_cfg_data[11:0];
                REG_BOOST_MIN_DUTY: r_boost_min  <= i_cfg_data[11:0];
                REG_PWM_PERIOD:     r_pwm_period <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_adc  <= i_adc_sample;
            r_tgt  <= i_target_voltage;
            r_mode <= i_converter_mode;
            r_chg  <= i_mode_changed;
            r_en   <= i_pwm_enable;
        end
    end

    // shared signed 18x17 multiplier
    assign w_is_buck = (r_mode == MODE_BUCK);

    always_comb begin
        case (i_cmd.mul_src)
            MUL_CAL: begin
                w_mul_a = $signed({6'b0, r_adc});
                w_mul_b = $signed({1'b0, r_cal_gain});
            end
            MUL_E0: begin
                w_mul_a = r_err;
                w_mul_b = w_is_buck ? BK0 : BS0;
            end
            MUL_E1: begin
                w_mul_a = r_err_p1;
                w_mul_b = w_is_buck ? BK1 : BS1;
            end
            MUL_E2: begin
                w_mul_a = r_err_p2;
                w_mul_b = w_is_buck ? BK2 : BS2;
            end
            MUL_BUCK: begin
                w_mul_a = $signed({6'b0, r_held_buck});
                w_mul_b = $signed({1'b0, r_pwm_period});
            end
            MUL_BOOST: begin
                w_mul_a = $signed({6'b0, r_held_boost});
                w_mul_b = $signed({1'b0, r_pwm_period});
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) r_prod <= w_mul_a * w_mul_b;
    end

    // calibrated voltage and capped error
    assign w_vout = $signed({2'b00, r_prod[27:12]}) + 18'(r_cal_offset);
    assign w_err  = $signed({2'b00, r_tgt}) - w_vout;

    always_ff @(posedge i_clk) begin
        if (i_cmd.err_calc) r_err <= (w_err > ERR_CAP) ? ERR_CAP : w_err;
    end

    // pid sum, integrator dropped on a mode change
    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_init) r_acc <= r_chg ? '0 : 37'(r_integ);
        else if (i_cmd.acc_add) r_acc <= r_acc + 37'(r_prod);
    end

    assign w_u = (r_acc > ACC_MAX) ? 32'sh7FFF_FFFF :
                 (r_acc < ACC_MIN) ? 32'sh8000_0000 : $signed(r_acc[31:0]);
    assign w_d = w_u[31:8];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err_p1     <= '0;
            r_err_p2     <= '0;
            r_integ      <= '0;
            r_held_buck  <= '0;
            r_held_boost <= '0;
        end else if (i_cmd.duty_upd) begin
            if (r_mode == MODE_IDLE) begin
                r_err_p1 <= '0;
                r_err_p2 <= '0;
                r_integ  <= '0;
                if (!r_en) r_held_buck <= r_buck_min;
            end else begin
                r_err_p2 <= r_err_p1;
                r_err_p1 <= r_err;
                r_integ  <= w_u;
                if (w_is_buck) begin
                    r_held_buck  <= r_en ? clamp_duty(w_d, r_buck_min, r_buck_max)
                                         : r_buck_min;
                    r_held_boost <= P_BOOST_DUTY_IN_BUCK;
                end else begin
                    if (!r_en) r_held_buck <= r_buck_min;
                    else if (r_mode == MODE_BOOST) r_held_buck <= P_BUCK_DUTY_IN_BOOST;
                    else r_held_buck <= P_BUCK_DUTY_IN_MIX;
                    r_held_boost <= clamp_duty(w_d, r_boost_min, r_boost_max);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.bc_cap) r_bc <= r_prod[27:12];
    end

    // result registers, r_prod holds boost duty times period here
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_buck  <= r_held_buck;
            r_out_boost <= r_held_boost;
            r_out_bc    <= r_bc;
            r_out_abc   <= r_bc[15:1];
            r_out_boc   <= r_pwm_period - r_prod[27:12];
        end
    end

    assign o_buck_duty           = r_out_buck;
    assign o_boost_duty          = r_out_boost;
    assign o_buck_compare        = r_out_bc;
    assign o_adc_trigger_compare = r_out_abc;
    assign o_boost_compare       = r_out_boc;

endmodule

>>> rtl/buck_boost_voltage_pid_core.sv
// top level of the buck-boost voltage loop controller
// depends on bbvp_pkg, bbvp_ctrl and bbvp_datapath
//
// usage
//   input channel: one beat per control tick carrying the raw adc sample,
//   the target voltage, the converter mode, the mode-change flag and the
//   pwm enable; taken at an edge with i_in_valid high and o_in_stall low
//   output channel: one beat per input beat with both q12 duties and the
//   buck, adc trigger and boost timer compare values; taken at an edge with
//   o_out_valid high and i_out_stall low
//   config port: i_cfg_we writes i_cfg_data into register i_cfg_index at the
//   edge, index 0 cal gain to 6 pwm period; other indexes are ignored
// timing
//   the result is loaded after the steps calibrate, error, three pid taps,
//   sum, duty, two compare scalings and final step; a new beat is taken only
//   once the last has left the final step; the steps come from the one
//   shared 18x17 multiplier, each product registered before it is used
//   a finished result waits in the output register, so the next beat runs
//   while the receiver stalls; a second result waits until the first is gone
// reset
//   i_rst_n (synchronous, active low) loads the default config, clears the
//   past errors, integrator and held duties and empties the output register
module buck_boost_voltage_pid_core #(
    parameter logic [11:0] P_BUCK_DUTY_IN_BOOST = bbvp_pkg::BUCK_DUTY_IN_BOOST,
    parameter logic [11:0] P_BUCK_DUTY_IN_MIX   = bbvp_pkg::BUCK_DUTY_IN_MIX,
    parameter logic [11:0] P_BOOST_DUTY_IN_BUCK = bbvp_pkg::BOOST_DUTY_IN_BUCK
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write port
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [11:0] i_adc_sample,
    input  logic [15:0] i_target_voltage,
    input  logic [1:0]  i_converter_mode,
    input  logic        i_mode_changed,
    input  logic        i_pwm_enable,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [11:0] o_buck_duty,
    output logic [11:0] o_boost_duty,
    output logic [15:0] o_buck_compare,
    output logic [14:0] o_adc_trigger_compare,
    output logic [15:0] o_boost_compare
);
    import bbvp_pkg::*;

    // command bundle from the sequencer
    t_dp_cmd w_cmd;

    bbvp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd)
    );

    // arithmetic, loop state and result registers
    bbvp_datapath #(
        .P_BUCK_DUTY_IN_BOOST (P_BUCK_DUTY_IN_BOOST),
        .P_BUCK_DUTY_IN_MIX   (P_BUCK_DUTY_IN_MIX),
        .P_BOOST_DUTY_IN_BUCK (P_BOOST_DUTY_IN_BUCK)
    ) u_datapath (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (w_cmd),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_index           (i_cfg_index),
        .i_cfg_data            (i_cfg_data),
        .i_adc_sample          (i_adc_sample),
        .i_target_voltage      (i_target_voltage),
        .i_converter_mode      (i_converter_mode),
        .i_mode_changed        (i_mode_changed),
        .i_pwm_enable          (i_pwm_enable),
        .o_buck_duty           (o_buck_duty),
        .o_boost_duty          (o_boost_duty),
        .o_buck_compare        (o_buck_compare),
        .o_adc_trigger_compare (o_adc_trigger_compare),
        .o_boost_compare       (o_boost_compare)
    );

endmodule
